// ----- rtl/rbfc_pkg.sv -----
// Shared types and constants of the record blob format checker
`timescale 1ns / 1ps
`default_nettype none

package rbfc_pkg;

	// expected format word after reset
	localparam logic [31:0] MAGIC_RESET = 32'h2601_1966;

	// byte roles
	localparam logic [3:0] ROLE_MAGIC      = 4'd0;
	localparam logic [3:0] ROLE_COUNT      = 4'd1;
	localparam logic [3:0] ROLE_NAME_CHAR  = 4'd2;
	localparam logic [3:0] ROLE_NAME_END   = 4'd3;
	localparam logic [3:0] ROLE_VAL_COUNT  = 4'd4;
	localparam logic [3:0] ROLE_VAL_LENGTH = 4'd5;
	localparam logic [3:0] ROLE_VAL_DATA   = 4'd6;
	localparam logic [3:0] ROLE_VAL_TERM   = 4'd7;
	localparam logic [3:0] ROLE_TRAILING   = 4'd8;
	localparam logic [3:0] ROLE_IGNORED    = 4'd9;

	// status codes
	localparam logic [2:0] ST_BUSY        = 3'd0;
	localparam logic [2:0] ST_DONE        = 3'd1;
	localparam logic [2:0] ST_TOO_SHORT   = 3'd2;
	localparam logic [2:0] ST_BAD_MAGIC   = 3'd3;
	localparam logic [2:0] ST_TOO_MANY    = 3'd4;
	localparam logic [2:0] ST_TRUNCATED   = 3'd5;
	localparam logic [2:0] ST_VAL_TOO_BIG = 3'd6;
	localparam logic [2:0] ST_ENDED_EARLY = 3'd7;

	// size limits of the format
	localparam logic [31:0] MIN_BLOB_BYTES    = 32'd8;
	localparam logic [31:0] HEADER_BYTES      = 32'd8;
	localparam logic [31:0] VCOUNT_BYTES      = 32'd4;
	localparam logic [31:0] MIN_ELEMENT_BYTES = 32'd10;
	localparam logic [31:0] NAME_RESERVE      = 32'd6;
	localparam logic [31:0] VALUE_OVERHEAD    = 32'd5;

	// parse phases
	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_MAGIC  = 4'd1,
		PH_COUNT  = 4'd2,
		PH_NAME   = 4'd3,
		PH_VCOUNT = 4'd4,
		PH_VLEN   = 4'd5,
		PH_VDATA  = 4'd6,
		PH_VTERM  = 4'd7,
		PH_TRAIL  = 4'd8
	} phase_t;

	// one input byte item
	typedef struct packed {
		logic [7:0]  data_byte;
		logic        blob_start;
		logic [31:0] blob_length;
		logic        blob_end;
	} byte_item_t;

	// one tagged result item
	typedef struct packed {
		logic [3:0]  byte_role;
		logic [29:0] element_number;
		logic [31:0] value_number;
		logic [31:0] field_value;
		logic        field_complete;
		logic [2:0]  status;
		logic        finished;
	} tag_item_t;

endpackage

`default_nettype wire

// ----- rtl/rbfc_parser.sv -----
// Parse state registers and the per-byte next-state and tagging logic
`timescale 1ns / 1ps
`default_nettype none

module rbfc_parser (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  accept,
	input  rbfc_pkg::byte_item_t item,
	input  wire                  cfg_we,
	input  wire [31:0]           cfg_wdata,
	output rbfc_pkg::tag_item_t  result
);

	// state registers
	rbfc_pkg::phase_t phase_q;
	logic [1:0]  biw_q;
	logic [31:0] wsh_q;
	logic [31:0] rem_q;
	logic [31:0] nlim_q;
	logic [31:0] elem_left_q;
	logic [31:0] val_left_q;
	logic [31:0] data_left_q;
	logic [29:0] elem_cnt_q;
	logic [31:0] val_cnt_q;
	logic [31:0] magic_q;

	// state as seen after a blob start is applied
	rbfc_pkg::phase_t e_phase;
	logic [1:0]  e_biw;
	logic [31:0] e_wsh, e_rem, e_nlim, e_elem_left, e_val_left, e_data_left, e_val_cnt;
	logic [29:0] e_elem_cnt;

	// next state
	rbfc_pkg::phase_t n_phase;
	logic [1:0]  n_biw;
	logic [31:0] n_wsh, n_rem, n_nlim, n_elem_left, n_val_left, n_data_left, n_val_cnt;
	logic [29:0] n_elem_cnt;

	logic [31:0] word;
	logic [34:0] word_x6;
	logic [32:0] vlen_need;
	logic        was_active, elem_fin, begin_el;
	logic [3:0]  role;
	logic [29:0] elem_num;
	logic [31:0] val_num, fval;
	logic        fcomp;
	logic [2:0]  st;

	// per-byte parse step
	always_comb begin
		if (item.blob_start) begin
			e_phase     = rbfc_pkg::PH_MAGIC;
			e_biw       = 2'd0;
			e_wsh       = 32'd0;
			e_rem       = item.blob_length;
			e_nlim      = 32'd0;
			e_elem_left = 32'd0;
			e_val_left  = 32'd0;
			e_data_left = 32'd0;
			e_elem_cnt  = 30'd0;
			e_val_cnt   = 32'd0;
		end else begin
			e_phase     = phase_q;
			e_biw       = biw_q;
			e_wsh       = wsh_q;
			e_rem       = rem_q;
			e_nlim      = nlim_q;
			e_elem_left = elem_left_q;
			e_val_left  = val_left_q;
			e_data_left = data_left_q;
			e_elem_cnt  = elem_cnt_q;
			e_val_cnt   = val_cnt_q;
		end

		n_phase     = e_phase;
		n_biw       = e_biw;
		n_wsh       = e_wsh;
		n_rem       = e_rem;
		n_nlim      = e_nlim;
		n_elem_left = e_elem_left;
		n_val_left  = e_val_left;
		n_data_left = e_data_left;
		n_elem_cnt  = e_elem_cnt;
		n_val_cnt   = e_val_cnt;

		role     = rbfc_pkg::ROLE_IGNORED;
		elem_num = 30'd0;
		val_num  = 32'd0;
		fval     = 32'd0;
		fcomp    = 1'b0;
		st       = rbfc_pkg::ST_BUSY;
		elem_fin = 1'b0;
		begin_el = 1'b0;

		was_active = (e_phase != rbfc_pkg::PH_IDLE) && (e_phase != rbfc_pkg::PH_TRAIL);
		word       = {item.data_byte, e_wsh[31:8]};
		word_x6    = {1'b0, word, 2'b00} + {2'b00, word, 1'b0};
		vlen_need  = {1'b0, word} + {1'b0, rbfc_pkg::VALUE_OVERHEAD};

		if (item.blob_start && (item.blob_length < rbfc_pkg::MIN_BLOB_BYTES)) begin
			role = rbfc_pkg::ROLE_MAGIC;
			st   = rbfc_pkg::ST_TOO_SHORT;
		end else begin
			case (e_phase)
				rbfc_pkg::PH_MAGIC, rbfc_pkg::PH_COUNT,
				rbfc_pkg::PH_VCOUNT, rbfc_pkg::PH_VLEN: begin
					case (e_phase)
						rbfc_pkg::PH_MAGIC:  role = rbfc_pkg::ROLE_MAGIC;
						rbfc_pkg::PH_COUNT:  role = rbfc_pkg::ROLE_COUNT;
						rbfc_pkg::PH_VCOUNT: role = rbfc_pkg::ROLE_VAL_COUNT;
						default:             role = rbfc_pkg::ROLE_VAL_LENGTH;
					endcase
					if ((e_phase == rbfc_pkg::PH_VCOUNT) || (e_phase == rbfc_pkg::PH_VLEN))
						elem_num = e_elem_cnt;
					if (e_phase == rbfc_pkg::PH_VLEN)
						val_num = e_val_cnt;
					n_wsh = word;
					if (e_biw != 2'd3) begin
						n_biw = e_biw + 2'd1;
					end else begin
						// last byte of a 32-bit word
						n_biw = 2'd0;
						fval  = word;
						fcomp = 1'b1;
						case (e_phase)
							rbfc_pkg::PH_MAGIC: begin
								if (word != magic_q)
									st = rbfc_pkg::ST_BAD_MAGIC;
								else
									n_phase = rbfc_pkg::PH_COUNT;
							end
							rbfc_pkg::PH_COUNT: begin
								n_rem = e_rem - rbfc_pkg::HEADER_BYTES;
								if (word == 32'd0) begin
									st = rbfc_pkg::ST_DONE;
								end else if (word_x6 > {3'b000, n_rem}) begin
									st = rbfc_pkg::ST_TOO_MANY;
								end else begin
									n_elem_left = word;
									begin_el    = 1'b1;
								end
							end
							rbfc_pkg::PH_VCOUNT: begin
								n_rem = e_rem - rbfc_pkg::VCOUNT_BYTES;
								if (word == 32'd0) begin
									// element without values ends here
									n_val_left = 32'd0;
									elem_fin   = 1'b1;
								end else begin
									n_val_left = word;
									n_phase    = rbfc_pkg::PH_VLEN;
								end
							end
							default: begin
								if (vlen_need > {1'b0, e_rem}) begin
									st = rbfc_pkg::ST_VAL_TOO_BIG;
								end else begin
									n_rem       = e_rem - vlen_need[31:0];
									n_data_left = word;
									n_phase     = (word == 32'd0) ? rbfc_pkg::PH_VTERM
									                              : rbfc_pkg::PH_VDATA;
								end
							end
						endcase
					end
				end
				rbfc_pkg::PH_NAME: begin
					elem_num = e_elem_cnt;
					n_rem    = e_rem - 32'd1;
					if (item.data_byte == 8'd0) begin
						role    = rbfc_pkg::ROLE_NAME_END;
						n_phase = rbfc_pkg::PH_VCOUNT;
						n_biw   = 2'd0;
						n_wsh   = 32'd0;
					end else begin
						role   = rbfc_pkg::ROLE_NAME_CHAR;
						n_nlim = e_nlim - 32'd1;
						if (n_nlim == 32'd0)
							st = rbfc_pkg::ST_TRUNCATED;
					end
				end
				rbfc_pkg::PH_VDATA: begin
					role        = rbfc_pkg::ROLE_VAL_DATA;
					elem_num    = e_elem_cnt;
					val_num     = e_val_cnt;
					n_data_left = e_data_left - 32'd1;
					if (n_data_left == 32'd0)
						n_phase = rbfc_pkg::PH_VTERM;
				end
				rbfc_pkg::PH_VTERM: begin
					role       = rbfc_pkg::ROLE_VAL_TERM;
					elem_num   = e_elem_cnt;
					val_num    = e_val_cnt;
					n_val_left = e_val_left - 32'd1;
					n_val_cnt  = e_val_cnt + 32'd1;
					if (n_val_left != 32'd0)
						n_phase = rbfc_pkg::PH_VLEN;
					else
						elem_fin = 1'b1;
				end
				rbfc_pkg::PH_TRAIL: begin
					role = rbfc_pkg::ROLE_TRAILING;
				end
				default: begin
					role = rbfc_pkg::ROLE_IGNORED;
				end
			endcase
		end

		// element finished: next element or done
		if (elem_fin) begin
			n_elem_left = e_elem_left - 32'd1;
			n_elem_cnt  = e_elem_cnt + 30'd1;
			if (n_elem_left == 32'd0)
				st = rbfc_pkg::ST_DONE;
			else
				begin_el = 1'b1;
		end

		// element start needs room for a minimal element
		if (begin_el) begin
			if (n_rem < rbfc_pkg::MIN_ELEMENT_BYTES) begin
				st = rbfc_pkg::ST_TRUNCATED;
			end else begin
				n_nlim    = n_rem - rbfc_pkg::NAME_RESERVE;
				n_val_cnt = 32'd0;
				n_phase   = rbfc_pkg::PH_NAME;
			end
		end

		// final status moves to trailing or idle
		if (st == rbfc_pkg::ST_DONE)
			n_phase = rbfc_pkg::PH_TRAIL;
		else if (st != rbfc_pkg::ST_BUSY)
			n_phase = rbfc_pkg::PH_IDLE;

		// end of blob
		if (item.blob_end) begin
			if ((st == rbfc_pkg::ST_BUSY) && was_active)
				st = rbfc_pkg::ST_ENDED_EARLY;
			n_phase = rbfc_pkg::PH_IDLE;
		end

		result.byte_role      = role;
		result.element_number = elem_num;
		result.value_number   = val_num;
		result.field_value    = fval;
		result.field_complete = fcomp;
		result.status         = st;
		result.finished       = (st != rbfc_pkg::ST_BUSY);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= rbfc_pkg::PH_IDLE;
			biw_q       <= 2'd0;
			wsh_q       <= 32'd0;
			rem_q       <= 32'd0;
			nlim_q      <= 32'd0;
			elem_left_q <= 32'd0;
			val_left_q  <= 32'd0;
			data_left_q <= 32'd0;
			elem_cnt_q  <= 30'd0;
			val_cnt_q   <= 32'd0;
		end else if (accept) begin
			phase_q     <= n_phase;
			biw_q       <= n_biw;
			wsh_q       <= n_wsh;
			rem_q       <= n_rem;
			nlim_q      <= n_nlim;
			elem_left_q <= n_elem_left;
			val_left_q  <= n_val_left;
			data_left_q <= n_data_left;
			elem_cnt_q  <= n_elem_cnt;
			val_cnt_q   <= n_val_cnt;
		end
	end

	// format word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q <= rbfc_pkg::MAGIC_RESET;
		end else if (cfg_we) begin
			magic_q <= cfg_wdata;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/rbfc_out_reg.sv -----
// Result register between the parser and the tag channel
`timescale 1ns / 1ps
`default_nettype none

module rbfc_out_reg (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 load,
	input  rbfc_pkg::tag_item_t din,
	input  wire                 stall,
	output logic                full,
	output rbfc_pkg::tag_item_t dout
);

	logic                valid_q;
	rbfc_pkg::tag_item_t data_q;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || !stall) begin
			valid_q <= load;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= din;
		end
	end

	assign full = valid_q;
	assign dout = data_q;

endmodule

`default_nettype wire

// ----- rtl/record_blob_format_checker_top.sv -----
// Top level of the record blob format checker
//
// channel  | dir | handshake                 | payload
// byte     | in  | byte_valid / byte_stall   | byte_item (rbfc_pkg::byte_item_t)
// tag      | out | tag_valid / tag_stall     | tag_item  (rbfc_pkg::tag_item_t)
// cfg      | in  | cfg_we                    | cfg_wdata (format word)
//
// one item per cycle while byte_stall is low; its tag appears in the cycle after acceptance
// the whole per-byte update of phase and counters is combinational logic
// byte_stall is high only while a tag is held and tag_stall is high
// reset clears the parse state and loads the default format word
`timescale 1ns / 1ps
`default_nettype none

module record_blob_format_checker_top (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  byte_valid,
	output logic                 byte_stall,
	input  rbfc_pkg::byte_item_t byte_item,
	output logic                 tag_valid,
	input  wire                  tag_stall,
	output rbfc_pkg::tag_item_t  tag_item,
	input  wire                  cfg_we,
	input  wire [31:0]           cfg_wdata
);

	logic                accept;
	logic                full;
	rbfc_pkg::tag_item_t result;

	// accept unless the held tag is stuck
	assign byte_stall = full && tag_stall;
	assign accept     = byte_valid && !byte_stall;

	rbfc_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (byte_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.result    (result)
	);

	rbfc_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (accept),
		.din    (result),
		.stall  (tag_stall),
		.full   (full),
		.dout   (tag_item)
	);

	assign tag_valid = full;

endmodule

`default_nettype wire

// ----- rtl/rbfc_checker.sv -----
// Port-level assertions for the record blob format checker and their bind
`timescale 1ns / 1ps
`default_nettype none

module rbfc_checker (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  byte_valid,
	input wire                  byte_stall,
	input rbfc_pkg::byte_item_t byte_item,
	input wire                  tag_valid,
	input wire                  tag_stall,
	input rbfc_pkg::tag_item_t  tag_item
);

	// a held tag stays put
	a_tag_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tag_valid && tag_stall |=> tag_valid && $stable(tag_item))
		else $error("stalled tag item changed");

	// every accepted byte yields a tag in the next cycle
	a_tag_follows: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && !byte_stall |=> tag_valid)
		else $error("accepted byte produced no tag");

	// short blob is rejected on its first byte
	a_short_blob: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && !byte_stall && byte_item.blob_start
		&& (byte_item.blob_length < rbfc_pkg::MIN_BLOB_BYTES)
		|=> tag_item.byte_role == rbfc_pkg::ROLE_MAGIC
		&& tag_item.status == rbfc_pkg::ST_TOO_SHORT && tag_item.finished)
		else $error("short blob not flagged");

	// finished marks exactly the final status
	a_finished: assert property (@(posedge clk) disable iff (!arst_n)
		tag_valid |-> tag_item.finished == (tag_item.status != rbfc_pkg::ST_BUSY))
		else $error("finished disagrees with status");

	// completed words only come from word fields
	a_field_role: assert property (@(posedge clk) disable iff (!arst_n)
		tag_valid && tag_item.field_complete
		|-> tag_item.byte_role == rbfc_pkg::ROLE_MAGIC
		|| tag_item.byte_role == rbfc_pkg::ROLE_COUNT
		|| tag_item.byte_role == rbfc_pkg::ROLE_VAL_COUNT
		|| tag_item.byte_role == rbfc_pkg::ROLE_VAL_LENGTH)
		else $error("field completed on a non-word byte");

endmodule

bind record_blob_format_checker_top rbfc_checker u_rbfc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.byte_valid (byte_valid),
	.byte_stall (byte_stall),
	.byte_item  (byte_item),
	.tag_valid  (tag_valid),
	.tag_stall  (tag_stall),
	.tag_item   (tag_item)
);

`default_nettype wire
